// ===== sv/microwire_eeprom_read_master_macros.svh =====
// Assertion macros for the Microwire EEPROM read master.
`ifndef MICROWIRE_EEPROM_READ_MASTER_MACROS_SVH
`define MICROWIRE_EEPROM_READ_MASTER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MWR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("microwire read master: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MWR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("microwire read master: next-cycle check failed");
`else
`define MWR_ASSERT_IMPL(label, ante, cons)
`define MWR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/mwr_pkg.sv =====
// Shared constants and types for the Microwire EEPROM read master.
package mwr_pkg;

    localparam int ADDR_BITS_DEF = 8;
    localparam int DATA_BITS_DEF = 16;
    localparam int ADDR_IN_W     = 8;
    localparam int WORD_W        = 16;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    typedef struct packed {
        logic              chip_select;
        logic              clock_pulse;
        logic              data_out_level;
        logic              busy_res;
        logic              word_valid;
        logic [WORD_W-1:0] read_word;
    } res_t;

endpackage

// ===== sv/mwr_if.sv =====
// Request and result channel interfaces of the Microwire EEPROM read master.
interface mwr_req_if import mwr_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [ADDR_IN_W-1:0] word_address;
    logic                 data_in_level;

    modport source (output valid, output req_type, output word_address,
                    output data_in_level, input ready);
    modport sink   (input valid, input req_type, input word_address,
                    input data_in_level, output ready);
endinterface

interface mwr_res_if import mwr_pkg::*;;
    logic              valid;
    logic              ready;
    logic              chip_select;
    logic              clock_pulse;
    logic              data_out_level;
    logic              busy_res;
    logic              word_valid;
    logic [WORD_W-1:0] read_word;

    modport source (output valid, output chip_select, output clock_pulse,
                    output data_out_level, output busy_res, output word_valid,
                    output read_word, input ready);
    modport sink   (input valid, input chip_select, input clock_pulse,
                    input data_out_level, input busy_res, input word_valid,
                    input read_word, output ready);
endinterface

// ===== sv/mwr_seq.sv =====
// Transaction sequencer: bit phase counter, address and data shift registers.
module mwr_seq import mwr_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 req_type,
    input  logic [ADDR_IN_W-1:0] word_address,
    input  logic                 data_in_level,
    output res_t                 res_next
);

    localparam int PH_LAST_I = 3 + ADDR_BITS + DATA_BITS;
    localparam int PH_W      = $clog2(PH_LAST_I + 1);

    localparam logic [PH_W-1:0] PH_OPCODE0 = PH_W'(2);
    localparam logic [PH_W-1:0] PH_DUMMY   = PH_W'(3 + ADDR_BITS);
    localparam logic [PH_W-1:0] PH_LAST    = PH_W'(PH_LAST_I);

    logic [PH_W-1:0]      phase_reg, phase_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [DATA_BITS-1:0] data_reg, data_next;
    logic                 active_reg, active_next;

    logic [DATA_BITS-1:0]          data_shifted;
    logic [WORD_W+DATA_BITS-1:0]   word_ext;
    logic [ADDR_BITS+ADDR_IN_W-1:0] addr_ext;

    always_comb
    begin
        data_shifted = {data_reg[DATA_BITS-2:0], data_in_level};
        word_ext     = {{WORD_W{1'b0}}, data_shifted};
        addr_ext     = {{ADDR_BITS{1'b0}}, word_address};

        phase_next  = phase_reg;
        addr_next   = addr_reg;
        data_next   = data_reg;
        active_next = active_reg;
        res_next    = '0;

        if (req_type == REQ_START)
        begin
            // ignore a start while a read runs
            if (!active_reg)
            begin
                addr_next   = addr_ext[ADDR_BITS-1:0];
                data_next   = '0;
                phase_next  = '0;
                active_next = 1'b1;
            end
            res_next.chip_select = 1'b1;
            res_next.busy_res    = 1'b1;
        end
        else if (active_reg)
        begin
            res_next.chip_select = 1'b1;
            res_next.clock_pulse = 1'b1;
            res_next.busy_res    = 1'b1;
            phase_next           = phase_reg + PH_W'(1);
            if (phase_reg < PH_OPCODE0)
            begin
                res_next.data_out_level = 1'b1;
            end
            else if (phase_reg == PH_OPCODE0)
            begin
                res_next.data_out_level = 1'b0;
            end
            else if (phase_reg < PH_DUMMY)
            begin
                // send address MSB first
                res_next.data_out_level = addr_reg[ADDR_BITS-1];
                addr_next               = {addr_reg[ADDR_BITS-2:0], 1'b0};
            end
            else if (phase_reg == PH_DUMMY)
            begin
                res_next.data_out_level = 1'b0;
            end
            else
            begin
                data_next = data_shifted;
                if (phase_reg == PH_LAST)
                begin
                    active_next          = 1'b0;
                    phase_next           = '0;
                    res_next.chip_select = 1'b0;
                    res_next.busy_res    = 1'b0;
                    res_next.word_valid  = 1'b1;
                    res_next.read_word   = word_ext[WORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            addr_reg   <= '0;
            data_reg   <= '0;
            active_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            addr_reg   <= addr_next;
            data_reg   <= data_next;
            active_reg <= active_next;
        end
    end

endmodule

// ===== sv/mwr_out_reg.sv =====
// Result register that holds one item until the sink takes it.
module mwr_out_reg import mwr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  res_t load_data,
    input  logic take,
    output logic free,
    output logic valid,
    output res_t data
);

    logic valid_reg, valid_next;
    res_t data_reg;

    assign free  = !valid_reg || take;
    assign valid = valid_reg;
    assign data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== sv/microwire_eeprom_read_master.sv =====
// Top level of the Microwire EEPROM read master (x16 organization).
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+-------------------------------------------------
//   req     | in  | valid/ready | req_type, word_address, data_in_level
//   res     | out | valid/ready | chip_select, clock_pulse, data_out_level,
//           |     |             | busy_res, word_valid, read_word
//
// The sequencer state and the incoming item produce the result in one
// combinational pass, and the result register holds it from the next cycle.
// One item enters per cycle while the result register is empty or being taken.
// A stalled result blocks req.ready only; nothing is dropped.
// rst_n clears the sequencer to idle and empties the result register.
`include "microwire_eeprom_read_master_macros.svh"

module microwire_eeprom_read_master import mwr_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input logic      clk,
    input logic      rst_n,
    mwr_req_if.sink  req,
    mwr_res_if.source res
);

    logic accept;
    logic free;
    logic out_valid;
    res_t res_next;
    res_t res_data;
    logic word_out;
    logic pulse_out;
    logic start_in;

    assign req.ready = free;
    assign accept    = req.valid && free;

    mwr_seq #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .req_type      (req.req_type),
        .word_address  (req.word_address),
        .data_in_level (req.data_in_level),
        .res_next      (res_next)
    );

    mwr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (res_next),
        .take      (res.ready),
        .free      (free),
        .valid     (out_valid),
        .data      (res_data)
    );

    assign res.valid          = out_valid;
    assign res.chip_select    = res_data.chip_select;
    assign res.clock_pulse    = res_data.clock_pulse;
    assign res.data_out_level = res_data.data_out_level;
    assign res.busy_res       = res_data.busy_res;
    assign res.word_valid     = res_data.word_valid;
    assign res.read_word      = res_data.read_word;

    assign word_out  = out_valid && res_data.word_valid;
    assign pulse_out = out_valid && res_data.clock_pulse;
    assign start_in  = accept && (req.req_type == REQ_START);

    `MWR_ASSERT_IMPL(a_stall_blocks_input, out_valid && !res.ready, !req.ready)
    `MWR_ASSERT_IMPL(a_word_ends_read, word_out, !res_data.chip_select && !res_data.busy_res)
    `MWR_ASSERT_IMPL(a_pulse_in_read, pulse_out, res_data.busy_res || res_data.word_valid)
    `MWR_ASSERT_NEXT(a_start_selects, start_in, out_valid && res_data.chip_select)

endmodule

// ===== dv/tb_microwire_eeprom_read_master.sv =====
// Self-checking testbench for the Microwire EEPROM read master.
`timescale 1ns / 1ps

module tb_microwire_eeprom_read_master;
    import mwr_pkg::*;

    localparam int PH_ADDR0    = 3;
    localparam int PH_DUMMY    = PH_ADDR0 + ADDR_BITS_DEF;
    localparam int PH_LAST     = PH_DUMMY + DATA_BITS_DEF;
    localparam int READ_TICKS  = PH_LAST + 1;
    localparam int RAND_ITEMS  = 1000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 16;
    localparam int MAX_CYCLES  = 400000;
    localparam int MAX_PRINTS  = 40;

    typedef struct {
        logic                 req_type;
        logic [ADDR_IN_W-1:0] word_address;
        logic                 data_in_level;
        int                   gap;
        bit                   drain;
    } mw_item_t;

    logic clk = 1'b0;
    logic rst_n;

    mwr_req_if req_ch ();
    mwr_res_if res_ch ();

    microwire_eeprom_read_master u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    always #2 clk = ~clk;

    mw_item_t pending_q[$];
    res_t     pin_expect_q[$];

    int total_items  = 0;
    int accepted_cnt = 0;
    int results_seen = 0;
    int err_count    = 0;
    int cycle_count  = 0;
    int gap_left     = 0;
    int tx_calm_left = 0;
    int rx_calm_left = 0;
    int stall_left   = 0;
    int hold_left    = 0;

    // Read sequencer mirror
    logic [4:0]               rd_phase  = '0;
    logic [ADDR_BITS_DEF-1:0] rd_addr   = '0;
    logic [DATA_BITS_DEF-1:0] rd_data   = '0;
    logic                     rd_active = 1'b0;

    function automatic res_t predict_pins(input logic rt, input logic [ADDR_IN_W-1:0] addr,
                                          input logic din);
        res_t r;
        int   ph;
        r = '0;
        if (rt == REQ_START)
        begin
            // a start while busy is ignored
            if (!rd_active)
            begin
                rd_addr   = addr[ADDR_BITS_DEF-1:0];
                rd_data   = '0;
                rd_phase  = '0;
                rd_active = 1'b1;
            end
            r.chip_select = 1'b1;
            r.busy_res    = 1'b1;
            return r;
        end
        if (!rd_active)
            return r;
        ph = int'(rd_phase);
        r.chip_select = 1'b1;
        r.clock_pulse = 1'b1;
        r.busy_res    = 1'b1;
        if (ph <= 1)
            r.data_out_level = 1'b1;
        else if (ph < PH_ADDR0)
            r.data_out_level = 1'b0;
        else if (ph < PH_DUMMY)
            r.data_out_level = rd_addr[ADDR_BITS_DEF - 1 - (ph - PH_ADDR0)];
        else if (ph > PH_DUMMY)
        begin
            rd_data = {rd_data[DATA_BITS_DEF-2:0], din};
            if (ph >= PH_LAST)
            begin
                rd_active      = 1'b0;
                rd_phase       = '0;
                r.chip_select  = 1'b0;
                r.busy_res     = 1'b0;
                r.word_valid   = 1'b1;
                r.read_word    = WORD_W'(rd_data);
                return r;
            end
        end
        rd_phase = rd_phase + 5'd1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        if (err_count < MAX_PRINTS)
            $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got,
                     want);
        err_count++;
    endtask

    task automatic add_item(input logic rt, input logic [ADDR_IN_W-1:0] addr, input logic din,
                            input bit drain);
        mw_item_t it;
        it.req_type      = rt;
        it.word_address  = addr;
        it.data_in_level = din;
        it.drain         = drain;
        if (tx_calm_left > 0)
        begin
            tx_calm_left--;
            it.gap = 0;
        end
        else
        begin
            it.gap = $urandom_range(0, 15);
            if ($urandom_range(0, 39) == 0)
                tx_calm_left = $urandom_range(30, 100);
        end
        pending_q.push_back(it);
        total_items++;
    endtask

    // Sender: predict on acceptance, then offer the next pending item
    always @(posedge clk or negedge rst_n)
    begin
        mw_item_t nxt;
        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.req_type      <= REQ_TICK;
            req_ch.word_address  <= '0;
            req_ch.data_in_level <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                pin_expect_q.push_back(predict_pins(req_ch.req_type, req_ch.word_address,
                                                    req_ch.data_in_level));
                accepted_cnt++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_q.size() == 0)
                    req_ch.valid <= 1'b0;
                else if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_q[0].drain && pin_expect_q.size() != 0)
                    req_ch.valid <= 1'b0;
                else
                begin
                    nxt = pending_q.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.req_type      <= nxt.req_type;
                    req_ch.word_address  <= nxt.word_address;
                    req_ch.data_in_level <= nxt.data_in_level;
                    gap_left = (pending_q.size() != 0) ? pending_q[0].gap : 0;
                end
            end
        end
    end

    // Receiver: check each result item against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (pin_expect_q.size() == 0)
                    report_mismatch("unexpected result item", res_ch.read_word, '0);
                else
                begin
                    want = pin_expect_q.pop_front();
                    if (res_ch.chip_select !== want.chip_select)
                        report_mismatch("chip_select", WORD_W'(res_ch.chip_select),
                                        WORD_W'(want.chip_select));
                    if (res_ch.clock_pulse !== want.clock_pulse)
                        report_mismatch("clock_pulse", WORD_W'(res_ch.clock_pulse),
                                        WORD_W'(want.clock_pulse));
                    if (res_ch.data_out_level !== want.data_out_level)
                        report_mismatch("data_out_level", WORD_W'(res_ch.data_out_level),
                                        WORD_W'(want.data_out_level));
                    if (res_ch.busy_res !== want.busy_res)
                        report_mismatch("busy_res", WORD_W'(res_ch.busy_res),
                                        WORD_W'(want.busy_res));
                    if (res_ch.word_valid !== want.word_valid)
                        report_mismatch("word_valid", WORD_W'(res_ch.word_valid),
                                        WORD_W'(want.word_valid));
                    if (res_ch.read_word !== want.read_word)
                        report_mismatch("read_word", res_ch.read_word, want.read_word);
                end
                if (rx_calm_left > 0)
                begin
                    rx_calm_left--;
                    stall_left = 0;
                end
                else
                begin
                    stall_left = $urandom_range(0, 15);
                    if ($urandom_range(0, 29) == 0)
                        rx_calm_left = $urandom_range(30, 90);
                end
                // long hold-off so the result register fills and req stalls
                if (results_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == MAX_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_microwire_eeprom_read_master: FAIL");
            $finish;
        end
    end

    initial
    begin
        int          dir_items;
        int          din_mode;
        logic [7:0]  addr;
        logic        din;
        bit          first_read;

        rst_n = 1'b0;

        // directed: idle tick, full read of the top address with all-ones data,
        // a start while busy, then a tick once idle again
        add_item(REQ_TICK, 8'hFF, 1'b1, 1'b0);
        add_item(REQ_START, 8'hFF, 1'b0, 1'b0);
        add_item(REQ_START, 8'h00, 1'b1, 1'b0);
        repeat (READ_TICKS)
            add_item(REQ_TICK, 8'h00, 1'b1, 1'b0);
        add_item(REQ_TICK, 8'hAA, 1'b0, 1'b0);
        dir_items  = total_items;
        first_read = 1'b1;

        while (total_items < dir_items + RAND_ITEMS)
        begin
            if ($urandom_range(0, 6) != 0)
            begin
                case ($urandom_range(0, 7))
                    0:       addr = 8'h00;
                    1:       addr = 8'hFF;
                    default: addr = 8'($urandom_range(0, 255));
                endcase
                din_mode = $urandom_range(0, 5);
                add_item(REQ_START, addr, 1'($urandom_range(0, 1)),
                         first_read || $urandom_range(0, 7) == 0);
                first_read = 1'b0;
                for (int k = 0; k < READ_TICKS; k++)
                begin
                    if ($urandom_range(0, 39) == 0)
                        add_item(REQ_START, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 1'b0);
                    case (din_mode)
                        0:       din = 1'b0;
                        1:       din = 1'b1;
                        default: din = 1'($urandom_range(0, 1));
                    endcase
                    add_item(REQ_TICK, 8'($urandom_range(0, 255)), din, 1'b0);
                end
            end
            else
            begin
                // noise: stray ticks and starts, possibly leaving a read half done
                repeat ($urandom_range(1, 4))
                    add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'b0);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt != total_items || pin_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_count == 0)
            $display("tb_microwire_eeprom_read_master: PASS");
        else
            $display("tb_microwire_eeprom_read_master: FAIL");
        $finish;
    end

endmodule
